// ----- hw/rtl/mns_pkg.sv -----
// ---------------------------------------------------------------------------
// Melody note sequencer package
// Shared widths, request codes, item structs and the tone half-period table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mns_pkg;

  // Store geometry
  localparam int SONG_COUNT  = 3;
  localparam int SONG_DEPTH  = 128;
  localparam int TONE_COUNT  = 21;
  localparam int STORE_DEPTH = SONG_COUNT * SONG_DEPTH;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  // Field and state widths
  localparam int REQ_W      = 3;
  localparam int SONG_W     = 2;
  localparam int ADDR_W     = 7;
  localparam int BYTE_W     = 8;
  localparam int POS_W      = $clog2(SONG_DEPTH + 1);
  localparam int BEAT_W     = 24;
  localparam int TICKS_W    = 28;
  localparam int TONE_W     = 5;
  localparam int HALF_W     = 10;
  localparam int LED_W      = 8;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_TICK  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PAUSE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SKIP  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_LOOP  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_WRITE = 3'd4;

  localparam logic [BEAT_W-1:0] BEAT_TICKS_RESET = 24'd120000;
  localparam logic [LED_W-1:0]  LED_DARK         = 8'hff;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [SONG_W-1:0] song_select;
    logic [ADDR_W-1:0] byte_address;
    logic [BYTE_W-1:0] note_byte;
  } req_item_t;

  typedef struct packed {
    logic              buzzer_level;
    logic [LED_W-1:0]  led_pattern;
    logic [SONG_W-1:0] song_now;
    logic [ADDR_W-1:0] note_position;
    logic              sounding;
    logic              paused_flag;
    logic              loop_single;
  } res_item_t;

  // Half period in timer ticks: 921600 / (2 * f) for each tone
  function automatic logic [HALF_W-1:0] tone_half(input logic [TONE_W-1:0] k);
    logic [HALF_W-1:0] h;
    case (k)
      5'd0:    h = 10'd988;
      5'd1:    h = 10'd881;
      5'd2:    h = 10'd785;
      5'd3:    h = 10'd699;
      5'd4:    h = 10'd660;
      5'd5:    h = 10'd587;
      5'd6:    h = 10'd523;
      5'd7:    h = 10'd494;
      5'd8:    h = 10'd440;
      5'd9:    h = 10'd392;
      5'd10:   h = 10'd349;
      5'd11:   h = 10'd329;
      5'd12:   h = 10'd293;
      5'd13:   h = 10'd261;
      5'd14:   h = 10'd247;
      5'd15:   h = 10'd220;
      5'd16:   h = 10'd196;
      5'd17:   h = 10'd175;
      5'd18:   h = 10'd165;
      5'd19:   h = 10'd147;
      5'd20:   h = 10'd131;
      default: h = 10'd988;
    endcase
    return h;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mns_song_ram.sv -----
// ---------------------------------------------------------------------------
// Song store RAM
// Single write port, single registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mns_song_ram #(
  parameter int DEPTH  = 384,
  parameter int DATA_W = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mns_player.sv -----
// ---------------------------------------------------------------------------
// Melody player core
// Holds the playback state, decodes the fetched note byte and steps one item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mns_player (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  beat_ticks_we,
  input  wire logic [mns_pkg::BEAT_W-1:0]            beat_ticks_wdata,
  input  wire logic                                  step,
  input  wire mns_pkg::req_item_t                    item,
  input  wire logic [mns_pkg::BYTE_W-1:0]            note_rdata,
  output logic      [mns_pkg::STORE_AW-1:0]          fetch_index,
  output mns_pkg::res_item_t                         result
);

  // Playback state
  logic [mns_pkg::BEAT_W-1:0]  beat_ticks;
  logic [mns_pkg::SONG_W-1:0]  song, song_next;
  logic [mns_pkg::POS_W-1:0]   position, position_next;
  logic                        note_active, note_active_next;
  logic [mns_pkg::TICKS_W-1:0] ticks_left, ticks_left_next;
  logic [mns_pkg::TONE_W-1:0]  tone_sel, tone_sel_next;
  logic [mns_pkg::HALF_W-1:0]  half_count, half_count_next;
  logic                        tone_on, tone_on_next;
  logic                        buzzer, buzzer_next;
  logic                        paused, paused_next;
  logic                        looping, looping_next;
  logic [mns_pkg::LED_W-1:0]   led, led_next;

  // Note byte decode
  logic                        pos_over;
  logic [mns_pkg::BYTE_W-1:0]  nb;
  logic [15:0]                 prod10;
  logic [13:0]                 prod100;
  logic [4:0]                  q10;
  logic [1:0]                  octave;
  logic [7:0]                  digit_wide;
  logic [3:0]                  digit;
  logic [4:0]                  beat_wide;
  logic [3:0]                  beat;
  logic                        is_tone;
  logic [mns_pkg::TONE_W-1:0]  tone_new;
  logic [mns_pkg::LED_W-1:0]   led_new;
  logic [mns_pkg::TICKS_W-1:0] ticks_new;
  logic [mns_pkg::SONG_W-1:0]  song_inc;

  // Split the byte into decimal digits by reciprocal multiplication
  always_comb begin
    pos_over   = position >= mns_pkg::POS_W'(mns_pkg::SONG_DEPTH);
    nb         = pos_over ? '0 : note_rdata;
    prod10     = 16'(nb) * 16'd205;
    prod100    = 14'(nb) * 14'd41;
    q10        = prod10[15:11];
    octave     = prod100[13:12];
    digit_wide = nb - {q10, 3'b000} - {2'b00, q10, 1'b0};
    digit      = digit_wide[3:0];
    beat_wide  = q10 - {octave, 3'b000} - {2'b00, octave, 1'b0};
    beat       = beat_wide[3:0];
    is_tone    = (digit >= 4'd1) && (digit <= 4'd7) && (octave != 2'd0);
    tone_new   = mns_pkg::TONE_W'(octave - 2'd1) * mns_pkg::TONE_W'(7)
               + mns_pkg::TONE_W'(digit) - mns_pkg::TONE_W'(1);
    led_new    = (digit <= 4'd7) ? (mns_pkg::LED_DARK << digit[2:0]) : mns_pkg::LED_DARK;
    ticks_new  = mns_pkg::TICKS_W'(beat) * mns_pkg::TICKS_W'(beat_ticks);
    song_inc   = (32'(song) == mns_pkg::SONG_COUNT - 1) ? '0
               : song + mns_pkg::SONG_W'(1);
  end

  // Step the state for one item
  always_comb begin
    song_next        = song;
    position_next    = position;
    note_active_next = note_active;
    ticks_left_next  = ticks_left;
    tone_sel_next    = tone_sel;
    half_count_next  = half_count;
    tone_on_next     = tone_on;
    buzzer_next      = buzzer;
    paused_next      = paused;
    looping_next     = looping;
    led_next         = led;
    if (step) begin
      unique case (item.req_type)
        mns_pkg::REQ_TICK: begin
          if (!note_active) begin
            // Fetch: song end, paused tone, or load the note
            if (nb == '0) begin
              position_next = '0;
              tone_on_next  = 1'b0;
              if (!looping) begin
                song_next = song_inc;
              end
            end else if (!(is_tone && paused)) begin
              if (is_tone) begin
                tone_sel_next   = tone_new;
                half_count_next = mns_pkg::tone_half(tone_new);
                tone_on_next    = 1'b1;
              end else begin
                tone_on_next = 1'b0;
              end
              led_next         = led_new;
              ticks_left_next  = ticks_new;
              note_active_next = 1'b1;
            end
          end else begin
            // Play: toggle on half period, count down the note
            if (tone_on) begin
              if (half_count <= mns_pkg::HALF_W'(1)) begin
                buzzer_next     = !buzzer;
                half_count_next = mns_pkg::tone_half(tone_sel);
              end else begin
                half_count_next = half_count - mns_pkg::HALF_W'(1);
              end
            end
            if (ticks_left <= mns_pkg::TICKS_W'(1)) begin
              ticks_left_next  = '0;
              note_active_next = 1'b0;
              tone_on_next     = 1'b0;
              position_next    = position + mns_pkg::POS_W'(1);
            end else begin
              ticks_left_next = ticks_left - mns_pkg::TICKS_W'(1);
            end
          end
        end
        mns_pkg::REQ_PAUSE: begin
          paused_next = !paused;
        end
        mns_pkg::REQ_SKIP: begin
          song_next        = song_inc;
          position_next    = '0;
          note_active_next = 1'b0;
          ticks_left_next  = '0;
          tone_on_next     = 1'b0;
        end
        mns_pkg::REQ_LOOP: begin
          looping_next = !looping;
        end
        default: begin
          // Byte writes go straight to the store; other codes do nothing
        end
      endcase
    end
  end

  // Forward the post-item song and position as the next fetch address
  assign fetch_index = mns_pkg::STORE_AW'(song_next) * mns_pkg::STORE_AW'(mns_pkg::SONG_DEPTH)
                     + mns_pkg::STORE_AW'(position_next[mns_pkg::ADDR_W-1:0]);

  // Result reflects the state after the item
  always_comb begin
    result.buzzer_level  = buzzer_next;
    result.led_pattern   = led_next;
    result.song_now      = song_next;
    result.note_position = position_next[mns_pkg::ADDR_W-1:0];
    result.sounding      = tone_on_next;
    result.paused_flag   = paused_next;
    result.loop_single   = looping_next;
  end

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_ticks  <= mns_pkg::BEAT_TICKS_RESET;
      song        <= '0;
      position    <= '0;
      note_active <= 1'b0;
      ticks_left  <= '0;
      tone_sel    <= '0;
      half_count  <= '0;
      tone_on     <= 1'b0;
      buzzer      <= 1'b0;
      paused      <= 1'b0;
      looping     <= 1'b0;
      led         <= mns_pkg::LED_DARK;
    end else begin
      if (beat_ticks_we) begin
        beat_ticks <= beat_ticks_wdata;
      end
      song        <= song_next;
      position    <= position_next;
      note_active <= note_active_next;
      ticks_left  <= ticks_left_next;
      tone_sel    <= tone_sel_next;
      half_count  <= half_count_next;
      tone_on     <= tone_on_next;
      buzzer      <= buzzer_next;
      paused      <= paused_next;
      looping     <= looping_next;
      led         <= led_next;
    end
  end

  // A tone only sounds within a loaded note
  a_tone_in_note: assert property (@(posedge clk) disable iff (rst)
    tone_on |-> note_active)
    else $error("tone on without a loaded note");

  // A loaded note always sits inside the song store
  a_note_in_range: assert property (@(posedge clk) disable iff (rst)
    note_active |-> (position < mns_pkg::POS_W'(mns_pkg::SONG_DEPTH)))
    else $error("note loaded past the end of the song");

  // Song number stays within the store
  a_song_range: assert property (@(posedge clk) disable iff (rst)
    32'(song) < mns_pkg::SONG_COUNT)
    else $error("song number out of range");

  // A sounding tone never has an empty half-period count
  a_half_loaded: assert property (@(posedge clk) disable iff (rst)
    tone_on |-> (half_count != '0))
    else $error("tone on with zero half-period count");

endmodule

`default_nettype wire

// ----- hw/rtl/melody_note_sequencer.sv -----
// ---------------------------------------------------------------------------
// Melody note sequencer
// Plays note-byte songs from an on-chip store to a square-wave buzzer.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req_item) carries ticks, key presses
//   and song byte writes; res channel (res_valid / res_stall / res_item)
//   returns one status item per request: buzzer level, LED bar, song,
//   position and mode flags after that request.
//   beat_ticks_we / beat_ticks_wdata set ticks per beat; write only when idle.
// Pipeline:
//   A taken request passes through the read stage (store read), then its
//   result is loaded into the output register. One item is taken every cycle
//   while the result side does not stall; the song store read keeps pace
//   because its address is forwarded from the state the previous item leaves.
// Reset:
//   Playback state clears, beat_ticks returns to 120000, LEDs go dark. The
//   song store keeps no reset value and must be written before it is played.
// Stall:
//   A stalled result holds in the output register; one more request is taken
//   into the read stage, after which req_stall rises until res_stall drops.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module melody_note_sequencer (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       beat_ticks_we,
  input  wire logic [mns_pkg::BEAT_W-1:0] beat_ticks_wdata,
  input  wire logic                       req_valid,
  output logic                            req_stall,
  input  wire mns_pkg::req_item_t         req_item,
  output logic                            res_valid,
  input  wire logic                       res_stall,
  output mns_pkg::res_item_t              res_item
);

  logic                            req_take;
  logic                            rd_valid;
  mns_pkg::req_item_t              rd_item;
  logic                            rd_adv;
  logic                            wr_en;
  logic [mns_pkg::STORE_AW-1:0]    wr_index;
  logic [mns_pkg::STORE_AW-1:0]    fetch_index;
  logic [mns_pkg::BYTE_W-1:0]      note_rdata;
  mns_pkg::res_item_t              step_result;

  // Handshake: read stage advances into a free or draining output register
  assign rd_adv    = rd_valid && (!res_valid || !res_stall);
  assign req_stall = rd_valid && !rd_adv;
  assign req_take  = req_valid && !req_stall;

  // Song byte writes with an in-range song and address land in the store when taken
  assign wr_en    = req_take && (req_item.req_type == mns_pkg::REQ_WRITE)
                 && (32'(req_item.song_select) < mns_pkg::SONG_COUNT)
                 && (32'(req_item.byte_address) < mns_pkg::SONG_DEPTH);
  assign wr_index = mns_pkg::STORE_AW'(req_item.song_select)
                  * mns_pkg::STORE_AW'(mns_pkg::SONG_DEPTH)
                  + mns_pkg::STORE_AW'(req_item.byte_address);

  mns_song_ram #(
    .DEPTH  (mns_pkg::STORE_DEPTH),
    .DATA_W (mns_pkg::BYTE_W)
  ) u_song_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_index),
    .wdata (req_item.note_byte),
    .re    (req_take),
    .raddr (fetch_index),
    .rdata (note_rdata)
  );

  mns_player u_player (
    .clk              (clk),
    .rst              (rst),
    .beat_ticks_we    (beat_ticks_we),
    .beat_ticks_wdata (beat_ticks_wdata),
    .step             (rd_adv),
    .item             (rd_item),
    .note_rdata       (note_rdata),
    .fetch_index      (fetch_index),
    .result           (step_result)
  );

  // Read stage: hold the item while its store byte arrives
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (req_take) begin
      rd_valid <= 1'b1;
    end else if (rd_adv) begin
      rd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      rd_item <= req_item;
    end
  end

  // Output register: load on advance, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rd_adv) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_adv) begin
      res_item <= step_result;
    end
  end

  // A taken item is in the read stage on the next cycle
  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    req_take |=> rd_valid)
    else $error("taken item missing from read stage");

  // An item leaving the read stage always shows up as a result
  a_adv_result: assert property (@(posedge clk) disable iff (rst)
    rd_adv |=> res_valid)
    else $error("advanced item produced no result");

  // Store writes only come from taken write requests
  a_write_src: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (req_take && (req_item.req_type == mns_pkg::REQ_WRITE)))
    else $error("store write without a write request");

endmodule

`default_nettype wire
